// File: sv/svm_pkg.sv
`timescale 1ns / 1ps

package svm_pkg;

    // Default sizes for the top level.
    localparam int NUM_VOICES_DEF   = 8;
    localparam int SAMPLE_WORDS_DEF = 65536;

    // Mix clamp and the longest sound a voice can hold.
    localparam int MIX_LIMIT  = 16384;
    localparam int MAX_LENGTH = 65536;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    // One input item.
    typedef struct packed {
        t_cmd               cmd;
        logic [15:0]        addr;
        logic signed [15:0] sample_data;
        logic [2:0]         voice;
        logic [16:0]        length;
        logic [7:0]         left_volume;
        logic [7:0]         right_volume;
        logic               loop_enable;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [7:0]         active_mask;
    } t_out_item;

endpackage

// File: sv/svm_if.sv
`timescale 1ns / 1ps

// Command channel into the mixer.
interface svm_in_if;
    logic              valid;
    logic              ready;
    svm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Mixed frame channel out of the mixer.
interface svm_out_if;
    logic               valid;
    logic               ready;
    svm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/sample_voice_mixer.sv
`timescale 1ns / 1ps

// Multi-voice sample playback mixer.
// i_in carries command items: write a sample word, start a voice, stop a
// voice, or tick one frame. Only a tick produces an item on o_out: the
// saturated left and right mix and the mask of voices still playing.
// i_in.ready is high only while the sequencer is idle; one command is worked
// on at a time.
// A stop is carried out in the cycle that accepts it. A write or a start goes
// through the accepting cycle, a step forming the quotient of the address by
// the memory size with a reciprocal multiplication, one subtracting its
// multiple, and one writing the sample memory or the voice record. A tick
// checks each slot, reads record and sample of each playing one and adds its
// scaled sample per channel, then delivers the frame. The shared gain
// multiplier, used once per channel, and each memory's one read port set the steps.
// A finished frame waits in an output register; while it is not taken, the
// block still accepts write, start and stop items, and a later tick holds
// its frame until the register is free.
// Reset clears all voices to inactive and drops o_out.valid. No clearing
// pass runs; sample memory is undefined until written.
module sample_voice_mixer #(
    parameter int NUM_VOICES   = svm_pkg::NUM_VOICES_DEF,
    parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svm_in_if.sink     i_in,
    svm_out_if.source  o_out
);

    localparam int AW  = $clog2(SAMPLE_WORDS);
    localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int RDW = AW + 16;
    // Rounded-up reciprocal of the memory size, scaled by 2^40; exact quotient
    // for every 16-bit address.
    localparam logic [32:0] RECIP = 33'((64'd1 << 40) / 64'(SAMPLE_WORDS) + 64'd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FOLD,
        S_WRITE,
        S_START,
        S_T_CHECK,
        S_T_RDV,
        S_T_RDS,
        S_T_ADD_L,
        S_T_ADD_R,
        S_T_OUT
    } t_state;

    // Per-voice playback record.
    typedef struct packed {
        logic [AW-1:0] start_a;
        logic [AW-1:0] cur_a;
        logic [15:0]   pos;
        logic [16:0]   len;
        logic [7:0]    lg;
        logic [7:0]    rg;
        logic          loop_en;
    } t_voice;

    t_state             r_state;
    svm_pkg::t_in_item  r_cmd;
    logic [15:0]        r_red;
    logic [7:0]         r_quo;
    logic [VW-1:0]      r_vidx;
    logic [NUM_VOICES-1:0] r_active;
    t_voice             r_vq;
    logic signed [15:0] r_sq;
    logic signed [23:0] r_prod;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    logic               r_out_valid;
    svm_pkg::t_out_item r_out;

    logic [15:0]        r_smem [SAMPLE_WORDS];
    t_voice             r_vmem [NUM_VOICES];

    logic [RDW-1:0]     red_ext;
    logic [AW-1:0]      addr_mod;
    logic [48:0]        quo_full;
    logic [31:0]        quo_back;
    logic [VW+2:0]      voice_ext;
    logic [VW-1:0]      cmd_vsel;
    logic               in_acc;
    logic               out_free;
    logic               last_voice;
    logic [7:0]         mul_gain;
    logic signed [24:0] mul_full;
    logic signed [15:0] n_mix;
    logic signed [15:0] mix_acc;
    logic signed [16:0] mix_sum;
    logic [16:0]        pos_next;
    logic               at_end;
    logic [AW-1:0]      cur_next;
    logic               vm_we;
    t_voice             vm_wdata;
    logic [VW-1:0]      vm_waddr;
    logic [NUM_VOICES+7:0] act_pad;
    logic [16:0]        len_sat;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_voice = (r_vidx == VW'(NUM_VOICES - 1));

    // Address reduction: quotient by reciprocal, then its multiple taken off.
    assign quo_full = {33'd0, r_red} * {16'd0, RECIP};
    assign quo_back = 32'(r_quo) * 32'(SAMPLE_WORDS);

    // Reduced address taken from the remainder.
    assign red_ext  = {{AW{1'b0}}, r_red};
    assign addr_mod = red_ext[AW-1:0];

    // Voice slot of the held command, sized to the slot index.
    assign voice_ext = {{VW{1'b0}}, r_cmd.voice};
    assign cmd_vsel  = voice_ext[VW-1:0];

    // Length clamped to the longest sound.
    assign len_sat = (r_cmd.length > 17'(svm_pkg::MAX_LENGTH))
                     ? 17'(svm_pkg::MAX_LENGTH) : r_cmd.length;

    // Shared multiplier: left gain first, then right gain.
    assign mul_gain = (r_state == S_T_RDS) ? r_vq.lg : r_vq.rg;
    assign mul_full = r_sq * $signed({1'b0, mul_gain});

    // Shared saturating adder: scaled term is the product floored by 256.
    always_comb begin
        mix_acc = (r_state == S_T_ADD_L) ? r_left : r_right;
        mix_sum = {mix_acc[15], mix_acc} + {r_prod[23], r_prod[23:8]};
        if (mix_sum > 17'sd16384) begin
            n_mix = 16'(svm_pkg::MIX_LIMIT);
        end else if (mix_sum < -17'sd16384) begin
            n_mix = -16'(svm_pkg::MIX_LIMIT);
        end else begin
            n_mix = mix_sum[15:0];
        end
    end

    // Position advance and address wrap of the current voice.
    assign pos_next = {1'b0, r_vq.pos} + 17'd1;
    assign at_end   = (pos_next >= r_vq.len);
    assign cur_next = (r_vq.cur_a == AW'(SAMPLE_WORDS - 1)) ? '0 : r_vq.cur_a + AW'(1);

    // Voice record write port: a start or the end of a voice's mix step.
    always_comb begin
        vm_we    = 1'b0;
        vm_waddr = r_vidx;
        vm_wdata = r_vq;
        case (r_state)
            S_START: begin
                vm_we            = 1'b1;
                vm_waddr         = cmd_vsel;
                vm_wdata.start_a = addr_mod;
                vm_wdata.cur_a   = addr_mod;
                vm_wdata.pos     = '0;
                vm_wdata.len     = len_sat;
                vm_wdata.lg      = r_cmd.left_volume;
                vm_wdata.rg      = r_cmd.right_volume;
                vm_wdata.loop_en = r_cmd.loop_enable;
            end
            S_T_ADD_R: begin
                vm_we = 1'b1;
                if (at_end) begin
                    vm_wdata.pos   = '0;
                    vm_wdata.cur_a = r_vq.start_a;
                end else begin
                    vm_wdata.pos   = pos_next[15:0];
                    vm_wdata.cur_a = cur_next;
                end
            end
            default: begin
                vm_we = 1'b0;
            end
        endcase
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_smem[addr_mod] <= r_cmd.sample_data;
        end
        r_sq <= r_smem[r_vq.cur_a];
    end

    // Voice record memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            r_vmem[vm_waddr] <= vm_wdata;
        end
        r_vq <= r_vmem[r_vidx];
    end

    // Mask of the first eight slots.
    assign act_pad = {8'd0, r_active};

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_vidx      <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd <= i_in.data;
                        r_red <= i_in.data.addr;
                        case (i_in.data.cmd)
                            svm_pkg::CMD_WRITE: begin
                                r_state <= S_MOD;
                            end
                            svm_pkg::CMD_START: begin
                                if ((32'(i_in.data.voice) < NUM_VOICES)
                                        && (i_in.data.length != '0)) begin
                                    r_state <= S_MOD;
                                end
                            end
                            svm_pkg::CMD_STOP: begin
                                if (32'(i_in.data.voice) < NUM_VOICES) begin
                                    r_active[VW'(i_in.data.voice)] <= 1'b0;
                                end
                            end
                            svm_pkg::CMD_TICK: begin
                                r_vidx  <= '0;
                                r_left  <= '0;
                                r_right <= '0;
                                r_state <= S_T_CHECK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    // Quotient of the address by the memory size.
                    r_quo   <= quo_full[47:40];
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    // The quotient's multiple never exceeds the address.
                    r_red   <= r_red - quo_back[15:0];
                    r_state <= (r_cmd.cmd == svm_pkg::CMD_WRITE) ? S_WRITE : S_START;
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                S_START: begin
                    r_active[cmd_vsel] <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_T_CHECK: begin
                    if (r_active[r_vidx]) begin
                        r_state <= S_T_RDV;
                    end else if (last_voice) begin
                        r_state <= S_T_OUT;
                    end else begin
                        r_vidx <= r_vidx + VW'(1);
                    end
                end
                S_T_RDV: begin
                    r_state <= S_T_RDS;
                end
                S_T_RDS: begin
                    r_prod  <= mul_full[23:0];
                    r_state <= S_T_ADD_L;
                end
                S_T_ADD_L: begin
                    r_left  <= n_mix;
                    r_prod  <= mul_full[23:0];
                    r_state <= S_T_ADD_R;
                end
                S_T_ADD_R: begin
                    r_right <= n_mix;
                    if (at_end && !r_vq.loop_en) begin
                        r_active[r_vidx] <= 1'b0;
                    end
                    if (last_voice) begin
                        r_state <= S_T_OUT;
                    end else begin
                        r_vidx  <= r_vidx + VW'(1);
                        r_state <= S_T_CHECK;
                    end
                end
                S_T_OUT: begin
                    if (out_free) begin
                        r_out.left_out    <= r_left;
                        r_out.right_out   <= r_right;
                        r_out.active_mask <= act_pad[7:0];
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// File: sv/svm_check.sv
`timescale 1ns / 1ps

// Port-level checks of the mixer.
module svm_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_left,
    input logic [15:0] i_right
);

    // A frame that is offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output item dropped before it was taken");

    // The mix never leaves the clamp range.
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_left) <= 16'sd16384) && ($signed(i_left) >= -16'sd16384)
            && ($signed(i_right) <= 16'sd16384) && ($signed(i_right) >= -16'sd16384))
        else $error("mixed output outside the clamp range");

    // An accepted tick keeps the block busy in the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd == svm_pkg::CMD_TICK)) |=> !i_in_ready)
        else $error("block ready right after accepting a tick");

    // A new frame appears only at the end of a tick, while the block is busy.
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("output item appeared without a tick in progress");

endmodule

bind sample_voice_mixer svm_check u_svm_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.data.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left      (o_out.data.left_out),
    .i_right     (o_out.data.right_out)
);

// File: verif/svm_checker.sv
`timescale 1ns / 1ps

// Watches the command and frame channels of the mixer. Every accepted command
// updates a private copy of the sample memory and the voice slots; every tick
// queues the frame it must produce, and every accepted frame is compared with
// the oldest one queued.
module svm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    svm_in_if    i_cmd_ch,
    svm_out_if   i_mix_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_frames
);

    localparam int REPORT_LIMIT = 10;

    logic signed [15:0] sample_mem [0:svm_pkg::SAMPLE_WORDS_DEF-1];
    logic [15:0]        voice_base  [svm_pkg::NUM_VOICES_DEF];
    logic [16:0]        voice_len   [svm_pkg::NUM_VOICES_DEF];
    logic [15:0]        voice_pos   [svm_pkg::NUM_VOICES_DEF];
    logic [7:0]         gain_l      [svm_pkg::NUM_VOICES_DEF];
    logic [7:0]         gain_r      [svm_pkg::NUM_VOICES_DEF];
    bit                 voice_loops [svm_pkg::NUM_VOICES_DEF];
    bit                 voice_on    [svm_pkg::NUM_VOICES_DEF];
    svm_pkg::t_out_item frames_due  [$];
    int                 fails;
    int                 frames_seen;

    // Sample times gain over 256, rounded toward minus infinity.
    function automatic int scaled(logic signed [15:0] s, logic [7:0] g);
        int p;
        p = int'(s) * int'(g);
        return p >>> 8;
    endfunction

    // One addition into a mix accumulator, clamped to the output range.
    function automatic int clamp_add(int acc, int term);
        int t;
        t = acc + term;
        if (t > svm_pkg::MIX_LIMIT)
            return svm_pkg::MIX_LIMIT;
        if (t < -svm_pkg::MIX_LIMIT)
            return -svm_pkg::MIX_LIMIT;
        return t;
    endfunction

    // Mix one frame over the playing voices, lowest slot first, and move each
    // of them on by one sample.
    function automatic svm_pkg::t_out_item mix_frame();
        int                 left;
        int                 right;
        logic [15:0]        word;
        logic signed [15:0] s;
        svm_pkg::t_out_item f;
        left  = 0;
        right = 0;
        f     = '0;
        for (int i = 0; i < svm_pkg::NUM_VOICES_DEF; i++) begin
            if (voice_on[i]) begin
                word  = voice_base[i] + voice_pos[i];
                s     = sample_mem[word];
                left  = clamp_add(left, scaled(s, gain_l[i]));
                right = clamp_add(right, scaled(s, gain_r[i]));
                if (voice_pos[i] + 17'd1 >= voice_len[i]) begin
                    if (voice_loops[i])
                        voice_pos[i] = '0;
                    else
                        voice_on[i] = 1'b0;
                end else begin
                    voice_pos[i] = voice_pos[i] + 16'd1;
                end
                f.active_mask[i] = voice_on[i];
            end
        end
        f.left_out  = 16'(left);
        f.right_out = 16'(right);
        return f;
    endfunction

    // Apply one accepted command item.
    task automatic take_cmd(svm_pkg::t_in_item it);
        case (it.cmd)
            svm_pkg::CMD_WRITE: begin
                sample_mem[it.addr] = it.sample_data;
            end
            svm_pkg::CMD_START: begin
                if (it.length != 0 && int'(it.voice) < svm_pkg::NUM_VOICES_DEF) begin
                    voice_base[it.voice]  = it.addr;
                    voice_len[it.voice]   = (it.length > svm_pkg::MAX_LENGTH)
                                            ? 17'(svm_pkg::MAX_LENGTH) : it.length;
                    voice_pos[it.voice]   = '0;
                    gain_l[it.voice]      = it.left_volume;
                    gain_r[it.voice]      = it.right_volume;
                    voice_loops[it.voice] = it.loop_enable;
                    voice_on[it.voice]    = 1'b1;
                end
            end
            svm_pkg::CMD_STOP: begin
                if (int'(it.voice) < svm_pkg::NUM_VOICES_DEF) begin
                    voice_on[it.voice]    = 1'b0;
                    voice_loops[it.voice] = 1'b0;
                end
            end
            svm_pkg::CMD_TICK: begin
                frames_due.push_back(mix_frame());
            end
            default: ;
        endcase
    endtask

    // Compare one accepted frame with the oldest one expected.
    task automatic check_frame(svm_pkg::t_out_item got);
        svm_pkg::t_out_item want;
        if (frames_due.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: frame L=%0d R=%0d mask=%02h arrived with none expected",
                         $time, got.left_out, got.right_out, got.active_mask);
            return;
        end
        want = frames_due.pop_front();
        frames_seen++;
        if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
            got.active_mask !== want.active_mask) begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: mismatch: exp L=%0d R=%0d m=%02h, got L=%0d R=%0d m=%02h",
                         $time, want.left_out, want.right_out, want.active_mask,
                         got.left_out, got.right_out, got.active_mask);
        end
    endtask

    // Sample both channels at the clock edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < svm_pkg::NUM_VOICES_DEF; i++) begin
                voice_base[i]  = '0;
                voice_len[i]   = '0;
                voice_pos[i]   = '0;
                gain_l[i]      = '0;
                gain_r[i]      = '0;
                voice_loops[i] = 1'b0;
                voice_on[i]    = 1'b0;
            end
            frames_due.delete();
        end else begin
            if (i_cmd_ch.valid && i_cmd_ch.ready)
                take_cmd(i_cmd_ch.data);
            if (i_mix_ch.valid && i_mix_ch.ready)
                check_frame(i_mix_ch.data);
        end
        o_fail_count <= fails;
        o_pending    <= frames_due.size();
        o_frames     <= frames_seen;
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

// Drives command items into the mixer and takes its frames with random gaps
// and stalls on both sides. A directed opening covers the empty mix, both
// clamp limits, rounding of negative products, address wraparound, looping,
// zero and oversized lengths, restart of a busy slot and stops. Random
// phrases follow: sample words are written, voices started over them and
// ticked, mixed with stops and fully random items. Before each tick, any word
// a playing voice is about to read that was never written gets written first.
module tb;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int IDLE_PCT       = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;

    logic clk = 1'b0;
    logic rst_n;

    svm_in_if  cmd_ch ();
    svm_out_if mix_ch ();

    int fail_count;
    int pending;
    int frames_checked;

    sample_voice_mixer DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (mix_ch)
    );

    svm_checker mix_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_ch     (cmd_ch),
        .i_mix_ch     (mix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frames     (frames_checked)
    );

    // Which words have been written, and where each voice is reading, so that
    // no tick reads a word that was never written.
    bit          written    [0:svm_pkg::SAMPLE_WORDS_DEF-1];
    logic [15:0] play_start [svm_pkg::NUM_VOICES_DEF];
    logic [16:0] play_len   [svm_pkg::NUM_VOICES_DEF];
    logic [15:0] play_pos   [svm_pkg::NUM_VOICES_DEF];
    bit          play_loop  [svm_pkg::NUM_VOICES_DEF];
    bit          play_on    [svm_pkg::NUM_VOICES_DEF];

    int n_write;
    int n_start;
    int n_stop;
    int n_tick;
    int n_counted;
    bit calm;
    int quiet = 0;

    always #10 clk = ~clk;

    // Frame side: stall at random, except during the calm stretch.
    always @(posedge clk) begin
        if (!rst_n)
            mix_ch.ready <= 1'b0;
        else
            mix_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // End the run when nothing has moved on either channel for too long.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (mix_ch.valid && mix_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic svm_pkg::t_in_item cmd_item(svm_pkg::t_cmd c, logic [15:0] a,
                                                   logic [15:0] d, int v, int len,
                                                   int lv, int rv, bit lp);
        svm_pkg::t_in_item it;
        it.cmd          = c;
        it.addr         = a;
        it.sample_data  = d;
        it.voice        = 3'(v);
        it.length       = 17'(len);
        it.left_volume  = 8'(lv);
        it.right_volume = 8'(rv);
        it.loop_enable  = lp;
        return it;
    endfunction

    function automatic svm_pkg::t_in_item rand_item();
        svm_pkg::t_in_item it;
        it.cmd          = svm_pkg::t_cmd'($urandom_range(3));
        it.addr         = 16'($urandom);
        it.sample_data  = 16'($urandom);
        it.voice        = 3'($urandom);
        it.length       = 17'($urandom);
        it.left_volume  = 8'($urandom);
        it.right_volume = 8'($urandom);
        it.loop_enable  = 1'($urandom);
        return it;
    endfunction

    // Mostly short sounds, some long, a few empty or past the maximum.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(16, 1);
        if (r < 80)
            return $urandom_range(300, 17);
        if (r < 86)
            return 0;
        if (r < 93)
            return svm_pkg::MAX_LENGTH;
        return $urandom_range(131071, svm_pkg::MAX_LENGTH + 1);
    endfunction

    // Follow an accepted item; returns 0 for items the mixer simply ignores.
    function automatic bit track(svm_pkg::t_in_item it);
        bit effective;
        effective = 1'b1;
        case (it.cmd)
            svm_pkg::CMD_WRITE: begin
                written[it.addr] = 1'b1;
                n_write++;
            end
            svm_pkg::CMD_START: begin
                n_start++;
                if (it.length == 0 || int'(it.voice) >= svm_pkg::NUM_VOICES_DEF) begin
                    effective = 1'b0;
                end else begin
                    play_start[it.voice] = it.addr;
                    play_len[it.voice]   = (it.length > svm_pkg::MAX_LENGTH)
                                           ? 17'(svm_pkg::MAX_LENGTH) : it.length;
                    play_pos[it.voice]   = '0;
                    play_loop[it.voice]  = it.loop_enable;
                    play_on[it.voice]    = 1'b1;
                end
            end
            svm_pkg::CMD_STOP: begin
                n_stop++;
                effective = play_on[it.voice];
                play_on[it.voice] = 1'b0;
            end
            svm_pkg::CMD_TICK: begin
                n_tick++;
                for (int i = 0; i < svm_pkg::NUM_VOICES_DEF; i++) begin
                    if (play_on[i]) begin
                        if (play_pos[i] + 17'd1 >= play_len[i]) begin
                            if (play_loop[i])
                                play_pos[i] = '0;
                            else
                                play_on[i] = 1'b0;
                        end else begin
                            play_pos[i] = play_pos[i] + 16'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return effective;
    endfunction

    // Offer one item, with random idle cycles ahead of it, until accepted.
    task automatic send(svm_pkg::t_in_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        do @(posedge clk); while (!cmd_ch.ready);
        if (track(it))
            n_counted++;
    endtask

    // Send an item; a tick is preceded by writes of any unwritten words
    // that the playing voices are about to read.
    task automatic issue(svm_pkg::t_in_item it);
        svm_pkg::t_in_item fill;
        logic [15:0]       word;
        if (it.cmd == svm_pkg::CMD_TICK) begin
            for (int i = 0; i < svm_pkg::NUM_VOICES_DEF; i++) begin
                word = play_start[i] + play_pos[i];
                if (play_on[i] && !written[word]) begin
                    fill      = rand_item();
                    fill.cmd  = svm_pkg::CMD_WRITE;
                    fill.addr = word;
                    send(fill);
                end
            end
        end
        send(it);
    endtask

    initial begin
        svm_pkg::t_in_item it;
        int                base_count;
        int                kind;
        int                nw;
        int                nv;
        int                nt;
        logic [15:0]       phrase_at;

        rst_n        <= 1'b0;
        calm         <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        for (int i = 0; i < svm_pkg::NUM_VOICES_DEF; i++) begin
            play_start[i] = '0;
            play_len[i]   = '0;
            play_pos[i]   = '0;
            play_loop[i]  = 1'b0;
            play_on[i]    = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty mix right after reset.
        issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));
        // Full-scale samples, a small positive one and a small negative one at the top address.
        issue(cmd_item(svm_pkg::CMD_WRITE, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_WRITE, 16'h0001, 16'h8000, 0, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_WRITE, 16'h0002, 16'h0001, 0, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 1'b0));
        // One voice at full left gain hits both clamp limits, then ends.
        issue(cmd_item(svm_pkg::CMD_START, 16'h0000, 16'h0000, 0, 2, 255, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));
        // Looping voice reading across the top of memory.
        issue(cmd_item(svm_pkg::CMD_START, 16'hFFFF, 16'h0000, 7, 2, 0, 255, 1'b1));
        repeat (3)
            issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));
        // Zero length is ignored; an oversized length is cut to the maximum.
        issue(cmd_item(svm_pkg::CMD_START, 16'h0001, 16'h0000, 0, 0, 255, 255, 1'b1));
        issue(cmd_item(svm_pkg::CMD_START, 16'h0000, 16'h0000, 1, 131071, 128, 128, 1'b0));
        // Restart the busy slot, and add a third voice.
        issue(cmd_item(svm_pkg::CMD_START, 16'h0002, 16'h0000, 7, 1, 255, 255, 1'b0));
        issue(cmd_item(svm_pkg::CMD_START, 16'h0001, 16'h0000, 2, 3, 255, 1, 1'b1));
        issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));
        // Stop an idle voice and a playing one.
        issue(cmd_item(svm_pkg::CMD_STOP, 16'h0000, 16'h0000, 5, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_STOP, 16'h0000, 16'h0000, 1, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_STOP, 16'h0000, 16'h0000, 2, 0, 0, 0, 1'b0));
        issue(cmd_item(svm_pkg::CMD_TICK, 16'h0000, 16'h0000, 0, 0, 0, 0, 1'b0));

        // Random part: phrases of writes, starts and ticks, plus stops and noise.
        base_count = n_counted;
        while (n_counted - base_count < RANDOM_ITEMS) begin
            calm <= (n_counted - base_count >= 450) && (n_counted - base_count < 650);
            kind = $urandom_range(99);
            if (kind < 55) begin
                phrase_at = 16'($urandom);
                if ($urandom_range(3) == 0)
                    phrase_at = 16'hFFF8 | 16'($urandom_range(7));
                nw = $urandom_range(12, 1);
                for (int k = 0; k < nw; k++) begin
                    it      = rand_item();
                    it.cmd  = svm_pkg::CMD_WRITE;
                    it.addr = phrase_at + 16'(k);
                    issue(it);
                end
                nv = $urandom_range(3, 1);
                for (int k = 0; k < nv; k++) begin
                    it        = rand_item();
                    it.cmd    = svm_pkg::CMD_START;
                    it.addr   = phrase_at + 16'($urandom_range(nw - 1));
                    it.length = 17'(pick_length());
                    issue(it);
                end
                nt = $urandom_range(10, 1);
                for (int k = 0; k < nt; k++) begin
                    it     = rand_item();
                    it.cmd = svm_pkg::CMD_TICK;
                    issue(it);
                end
            end else if (kind < 72) begin
                nv = $urandom_range(4, 1);
                for (int k = 0; k < nv; k++) begin
                    it     = rand_item();
                    it.cmd = svm_pkg::CMD_STOP;
                    issue(it);
                end
                it     = rand_item();
                it.cmd = svm_pkg::CMD_TICK;
                issue(it);
            end else begin
                nt = $urandom_range(6, 1);
                for (int k = 0; k < nt; k++)
                    issue(rand_item());
            end
        end

        // Let every expected frame come out, then allow for stragglers.
        calm         <= 1'b0;
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d writes, %0d starts, %0d stops, %0d ticks; %0d frames checked.",
                 n_write, n_start, n_stop, n_tick, frames_checked);
        $display("Mismatches: %0d.", fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/svm_pkg.sv
sv/svm_if.sv
sv/sample_voice_mixer.sv
sv/svm_check.sv
verif/svm_checker.sv
verif/tb.sv
